// File: src/form_url_percent_encoder_defines.svh
// Assertion macros shared by the checker of the encoder.
`ifndef FORM_URL_PERCENT_ENCODER_DEFINES_SVH
`define FORM_URL_PERCENT_ENCODER_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define FUPE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition in one cycle that requires another in the next cycle.
`define FUPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/fupe_pkg.sv
package fupe_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;

  localparam logic [3:0] NEWLINE_LEN = 4'd6;

  typedef enum logic [1:0] {
    MK_NONE,
    MK_NEWLINE,
    MK_CHAR,
    MK_HEX
  } main_kind_t;

  // One classified input byte, as handed from the front end to the back end.
  typedef struct packed {
    logic       pre_newline;
    main_kind_t kind;
    logic [7:0] char_byte;
    logic       last;
  } job_t;

  function automatic logic is_plain(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A) || (b == CH_DASH);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h37 + {4'd0, nib};
    end
    return c;
  endfunction

  // Characters of the sequence %0D%0A.
  function automatic logic [7:0] newline_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = CH_PERCENT;
      3'd1:    c = 8'h30;
      3'd2:    c = 8'h44;
      3'd3:    c = CH_PERCENT;
      3'd4:    c = 8'h30;
      3'd5:    c = 8'h41;
      default: c = CH_PERCENT;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] main_len(input main_kind_t k);
    logic [3:0] n;
    unique case (k)
      MK_NONE:    n = 4'd0;
      MK_NEWLINE: n = NEWLINE_LEN;
      MK_CHAR:    n = 4'd1;
      MK_HEX:     n = 4'd3;
      default:    n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

// File: src/fupe_front.sv
module fupe_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output logic          in_ready,
  input  logic          q_ready,
  output logic          q_push,
  output fupe_pkg::job_t q_job
);
  import fupe_pkg::*;

  logic held_cr_r;
  logic held_cr_nxt;
  logic accept;
  logic lf_closes_cr;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  // A held CR followed by LF forms one line ending; the LF adds nothing.
  assign lf_closes_cr = held_cr_r && (in_byte == CH_LF);

  always_comb begin
    q_job.pre_newline = held_cr_r;
    q_job.kind        = MK_NONE;
    q_job.char_byte   = in_byte;
    q_job.last        = in_last;
    held_cr_nxt       = held_cr_r;
    if (!lf_closes_cr) begin
      if (in_byte == CH_CR) begin
        q_job.kind = in_last ? MK_NEWLINE : MK_NONE;
      end else if (in_byte == CH_LF) begin
        q_job.kind = MK_NEWLINE;
      end else if (is_plain(in_byte)) begin
        q_job.kind = MK_CHAR;
      end else if (in_byte == CH_SPACE) begin
        q_job.kind      = MK_CHAR;
        q_job.char_byte = CH_PLUS;
      end else begin
        q_job.kind = MK_HEX;
      end
    end
    if (accept) begin
      held_cr_nxt = !lf_closes_cr && (in_byte == CH_CR) && !in_last;
    end
  end

  // A CR that is only held produces nothing yet, so no job is queued.
  assign q_push = accept && (q_job.pre_newline || (q_job.kind != MK_NONE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cr_r <= 1'b0;
    end else begin
      held_cr_r <= held_cr_nxt;
    end
  end

endmodule

// File: src/fupe_queue.sv
module fupe_queue #(
  parameter int DEPTH = fupe_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fupe_pkg::job_t push_job,
  output logic           not_full,
  input  logic           pop,
  output logic           not_empty,
  output fupe_pkg::job_t head_job
);
  import fupe_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign not_full  = (count_r != CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head_job  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: src/fupe_back.sv
module fupe_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  fupe_pkg::job_t q_job,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_char,
  output logic           out_run_end,
  output logic           out_msg_end
);
  import fupe_pkg::*;

  logic [3:0] pos_r, pos_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r;
  logic       out_run_end_r;
  logic       out_msg_end_r;

  logic       advance;
  logic [3:0] total;
  logic       is_final;
  logic       in_pre;
  logic [3:0] main_pos;
  logic [7:0] cur_char;

  assign advance  = q_valid && (!out_valid_r || out_ready);
  assign total    = (q_job.pre_newline ? NEWLINE_LEN : 4'd0) + main_len(q_job.kind);
  assign is_final = (pos_r == total - 4'd1);
  assign in_pre   = q_job.pre_newline && (pos_r < NEWLINE_LEN);
  assign main_pos = q_job.pre_newline ? pos_r - NEWLINE_LEN : pos_r;

  always_comb begin
    if (in_pre) begin
      cur_char = newline_char(pos_r[2:0]);
    end else begin
      case (q_job.kind)
        MK_NEWLINE: cur_char = newline_char(main_pos[2:0]);
        MK_CHAR:    cur_char = q_job.char_byte;
        MK_HEX: begin
          if (main_pos == 4'd0) begin
            cur_char = CH_PERCENT;
          end else if (main_pos == 4'd1) begin
            cur_char = hex_char(q_job.char_byte[7:4]);
          end else begin
            cur_char = hex_char(q_job.char_byte[3:0]);
          end
        end
        default:    cur_char = CH_PERCENT;
      endcase
    end
  end

  always_comb begin
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_pop         = 1'b0;
    if (advance) begin
      out_valid_nxt = 1'b1;
      if (is_final) begin
        pos_nxt = 4'd0;
        q_pop   = 1'b1;
      end else begin
        pos_nxt = pos_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_char_r    <= cur_char;
      out_run_end_r <= is_final;
      out_msg_end_r <= is_final && q_job.last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_char    = out_char_r;
  assign out_run_end = out_run_end_r;
  assign out_msg_end = out_msg_end_r;

endmodule

// File: src/form_url_percent_encoder.sv
// Form-URL encoder for a byte stream. Each input transaction carries one raw
// byte, with tlast marking the final byte of a buffer; each output transaction
// carries one encoded character. Letters, digits and '-' pass through, space
// becomes '+', any line ending (CR, LF or CR LF) becomes %0D%0A, and every
// other byte becomes '%' and two upper-case hex digits. A CR without tlast
// produces nothing until the next byte arrives. The output side delivers one
// character per cycle while out_tready stays high and jobs are queued. A byte
// yields 1 character for a plain byte, 3 for an escaped one, 6 for a line
// ending, 9 when a held CR is followed by an escaped byte and 12 when a held CR
// is followed by a CR that ends the buffer. Input bytes are classified
// combinationally and are taken every cycle while the QUEUE_DEPTH-entry job
// queue has room; the character sequencer behind it sets the sustained rate.
// out_tuser flags the last character produced by each input byte and out_tlast
// the last one of a buffer.
module form_url_percent_encoder #(
  parameter int QUEUE_DEPTH = fupe_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tuser,  // [0] run_end
  output logic       out_tlast   // message_end
);
  import fupe_pkg::*;

  logic q_push, q_not_full, q_pop, q_not_empty;
  job_t push_job, head_job;

  fupe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .q_ready  (q_not_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  fupe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  fupe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_not_empty),
    .q_job       (head_job),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_char    (out_tdata),
    .out_run_end (out_tuser),
    .out_msg_end (out_tlast)
  );

endmodule

// File: src/fupe_checker.sv
`include "form_url_percent_encoder_defines.svh"

module fupe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);

  logic       out_alnum;
  logic       out_legal;
  logic       out_stalled;
  logic       in_stalled;
  logic [9:0] out_word;
  logic [8:0] in_word;

  assign out_alnum   = (out_tdata >= 8'h30 && out_tdata <= 8'h39) ||
                       (out_tdata >= 8'h41 && out_tdata <= 8'h5A) ||
                       (out_tdata >= 8'h61 && out_tdata <= 8'h7A);
  assign out_legal   = out_alnum || (out_tdata == 8'h2D) || (out_tdata == 8'h2B) ||
                       (out_tdata == 8'h25);
  assign out_stalled = out_tvalid && !out_tready;
  assign in_stalled  = in_tvalid && !in_tready;
  assign out_word    = {out_tdata, out_tuser, out_tlast};
  assign in_word     = {in_tdata, in_tlast};

  // A stalled character stays put until it is taken.
  `FUPE_ASSERT_NEXT(a_out_hold, out_stalled, out_tvalid && $stable(out_word), "stalled output changed")

  // A stalled input byte stays put until it is taken.
  `FUPE_ASSERT_NEXT(a_in_hold, in_stalled, in_tvalid && $stable(in_word), "stalled input changed")

  // Only the encoding alphabet ever leaves the block.
  `FUPE_ASSERT(a_out_alphabet, !out_tvalid || out_legal, "character outside the encoding alphabet")

  // The end of a buffer is always the end of a byte's characters.
  `FUPE_ASSERT(a_last_is_run_end, !(out_tvalid && out_tlast) || out_tuser, "tlast without tuser")

  // An escape sequence never ends on its percent sign.
  `FUPE_ASSERT(a_percent_not_final, !(out_tvalid && out_tdata == 8'h25 && out_tuser), "percent sign ends a byte")

endmodule

bind form_url_percent_encoder fupe_checker u_fupe_checker (.*);
